[rtl/core/ordered_multiset_engine_macros.svh]
// Assertion macros for the checker file.
`ifndef ORDERED_MULTISET_ENGINE_MACROS_SVH
`define ORDERED_MULTISET_ENGINE_MACROS_SVH
// Same-cycle implication, sampled on the rising clock, off during reset.
`define OME_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered multiset engine assertion failed");
// Next-cycle implication, sampled on the rising clock, off during reset.
`define OME_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ordered multiset engine assertion failed");
`endif

[rtl/core/omse_pkg.sv]
package omse_pkg;
    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int OCC_W         = 11;
    localparam int STATUS_W      = 2;
    localparam int OP_W          = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_SEARCH  = 3'd2,
        OP_COUNT   = 3'd3,
        OP_LOWER   = 3'd4,
        OP_UPPER   = 3'd5,
        OP_CLOSEST = 3'd6
    } t_op;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_LO_RD, S_LO_CMP, S_HI_RD, S_HI_CMP, S_DISPATCH,
        S_INS_RD, S_INS_WR, S_INS_PUT, S_REM_RD, S_REM_WR,
        S_SUCC_RD, S_SUCC_SAVE, S_PRED_RD, S_PRED_SAVE, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        A_MID, A_PTR, A_PTRM1, A_LO, A_LOM1, A_HI
    } t_addr_sel;

    typedef struct packed {
        logic      cap;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      step_lo;
        logic      step_hi;
        logic      save_lo;
        logic      save_hi;
        logic      ptr_ins;
        logic      ptr_rem;
        logic      wr_ins;
        logic      wr_rem;
        logic      wr_put;
        logic      save_succ;
        logic      save_pred;
        logic      finish;
    } t_cmd;

    typedef struct packed {
        logic            bs_done;
        logic            full;
        logic            present;
        logic            ins_more;
        logic            rem_more;
        logic            out_free;
        logic [OP_W-1:0] op;
    } t_stat;
endpackage

[rtl/core/omse_ctrl.sv]
module omse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  omse_pkg::t_stat  i_stat,
    output omse_pkg::t_cmd   o_cmd
);
    omse_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= omse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            omse_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = omse_pkg::S_LO_RD;
                end
            end
            omse_pkg::S_LO_RD: begin
                if (i_stat.bs_done) begin
                    o_cmd.save_lo = 1'b1;
                    n_state       = omse_pkg::S_HI_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = omse_pkg::A_MID;
                    n_state      = omse_pkg::S_LO_CMP;
                end
            end
            omse_pkg::S_LO_CMP: begin
                o_cmd.step_lo = 1'b1;
                n_state       = omse_pkg::S_LO_RD;
            end
            omse_pkg::S_HI_RD: begin
                if (i_stat.bs_done) begin
                    o_cmd.save_hi = 1'b1;
                    n_state       = omse_pkg::S_DISPATCH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = omse_pkg::A_MID;
                    n_state      = omse_pkg::S_HI_CMP;
                end
            end
            omse_pkg::S_HI_CMP: begin
                o_cmd.step_hi = 1'b1;
                n_state       = omse_pkg::S_HI_RD;
            end
            omse_pkg::S_DISPATCH: begin
                case (i_stat.op)
                    omse_pkg::OP_INSERT: begin
                        if (i_stat.full) begin
                            n_state = omse_pkg::S_DONE;
                        end else begin
                            o_cmd.ptr_ins = 1'b1;
                            n_state       = omse_pkg::S_INS_RD;
                        end
                    end
                    omse_pkg::OP_REMOVE: begin
                        if (i_stat.present) begin
                            o_cmd.ptr_rem = 1'b1;
                            n_state       = omse_pkg::S_REM_RD;
                        end else begin
                            n_state = omse_pkg::S_DONE;
                        end
                    end
                    omse_pkg::OP_LOWER, omse_pkg::OP_UPPER, omse_pkg::OP_CLOSEST: begin
                        n_state = omse_pkg::S_SUCC_RD;
                    end
                    default: begin
                        n_state = omse_pkg::S_DONE;
                    end
                endcase
            end
            omse_pkg::S_INS_RD: begin
                if (i_stat.ins_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = omse_pkg::A_PTRM1;
                    n_state      = omse_pkg::S_INS_WR;
                end else begin
                    n_state = omse_pkg::S_INS_PUT;
                end
            end
            omse_pkg::S_INS_WR: begin
                o_cmd.wr_ins = 1'b1;
                n_state      = omse_pkg::S_INS_RD;
            end
            omse_pkg::S_INS_PUT: begin
                o_cmd.wr_put = 1'b1;
                n_state      = omse_pkg::S_DONE;
            end
            omse_pkg::S_REM_RD: begin
                if (i_stat.rem_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = omse_pkg::A_PTR;
                    n_state      = omse_pkg::S_REM_WR;
                end else begin
                    n_state = omse_pkg::S_DONE;
                end
            end
            omse_pkg::S_REM_WR: begin
                o_cmd.wr_rem = 1'b1;
                n_state      = omse_pkg::S_REM_RD;
            end
            omse_pkg::S_SUCC_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = (i_stat.op == omse_pkg::OP_UPPER) ? omse_pkg::A_HI
                                                                 : omse_pkg::A_LO;
                n_state      = omse_pkg::S_SUCC_SAVE;
            end
            omse_pkg::S_SUCC_SAVE: begin
                o_cmd.save_succ = 1'b1;
                n_state = (i_stat.op == omse_pkg::OP_CLOSEST) ? omse_pkg::S_PRED_RD
                                                              : omse_pkg::S_DONE;
            end
            omse_pkg::S_PRED_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = omse_pkg::A_LOM1;
                n_state      = omse_pkg::S_PRED_SAVE;
            end
            omse_pkg::S_PRED_SAVE: begin
                o_cmd.save_pred = 1'b1;
                n_state         = omse_pkg::S_DONE;
            end
            omse_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = omse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = omse_pkg::S_IDLE;
            end
        endcase
    end
endmodule

[rtl/core/omse_dp.sv]
module omse_dp #(
    parameter int CAPACITY  = omse_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = omse_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [omse_pkg::OP_W-1:0]     i_opcode,
    input  logic signed [KEY_WIDTH-1:0]   i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [omse_pkg::STATUS_W-1:0] o_status,
    output logic signed [KEY_WIDTH-1:0]   o_answer_value,
    output logic [omse_pkg::OCC_W-1:0]    o_occurrences,
    output logic                          o_present,
    input  omse_pkg::t_cmd                i_cmd,
    output omse_pkg::t_stat               o_stat
);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    logic [KEY_WIDTH-1:0] r_mem [CAPACITY];
    logic [KEY_WIDTH-1:0] r_rdata, r_succ, r_pred, r_key;
    logic [omse_pkg::OP_W-1:0] r_op;
    logic [CNT_W-1:0] r_low, r_high, r_lo, r_hi, r_ptr, r_count;
    logic             r_out_valid;
    logic [omse_pkg::STATUS_W-1:0] r_status, n_status;
    logic [KEY_WIDTH-1:0]          r_ans, n_ans;
    logic [omse_pkg::OCC_W-1:0]    r_occ, n_occ;
    logic                          r_pres, n_pres;
    logic [CNT_W-1:0] n_count;

    logic [CNT_W:0]      mid_sum;
    logic [CNT_W-1:0]    mid, copies, rd_cnt, wr_cnt;
    logic                wr_en;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                rd_lt, rd_le, present;
    logic [KEY_WIDTH:0]  dp, ds;

    assign mid_sum = {1'b0, r_low} + {1'b0, r_high};
    assign mid     = mid_sum[CNT_W:1];
    assign copies  = r_hi - r_lo;
    assign present = (r_hi != r_lo);
    assign rd_lt   = $signed(r_rdata) < $signed(r_key);
    assign rd_le   = $signed(r_rdata) <= $signed(r_key);

    always_comb begin
        case (i_cmd.rd_sel)
            omse_pkg::A_MID:   rd_cnt = mid;
            omse_pkg::A_PTR:   rd_cnt = r_ptr;
            omse_pkg::A_PTRM1: rd_cnt = r_ptr - 1'b1;
            omse_pkg::A_LO:    rd_cnt = r_lo;
            omse_pkg::A_LOM1:  rd_cnt = r_lo - 1'b1;
            omse_pkg::A_HI:    rd_cnt = r_hi;
            default:           rd_cnt = r_lo;
        endcase
        wr_en   = i_cmd.wr_ins | i_cmd.wr_rem | i_cmd.wr_put;
        wr_data = i_cmd.wr_put ? r_key : r_rdata;
        if (i_cmd.wr_ins) begin
            wr_cnt = r_ptr;
        end else if (i_cmd.wr_rem) begin
            wr_cnt = r_ptr - copies;
        end else begin
            wr_cnt = r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_cnt[ADDR_W-1:0]];
        end
        if (wr_en) begin
            r_mem[wr_cnt[ADDR_W-1:0]] <= wr_data;
        end
    end

    assign dp = {r_key[KEY_WIDTH-1], r_key} - {r_pred[KEY_WIDTH-1], r_pred};
    assign ds = {r_succ[KEY_WIDTH-1], r_succ} - {r_key[KEY_WIDTH-1], r_key};

    always_comb begin
        n_status = omse_pkg::ST_NONE;
        n_ans    = '0;
        n_occ    = '0;
        n_pres   = present;
        n_count  = r_count;
        case (r_op)
            omse_pkg::OP_INSERT: begin
                if (r_count >= CNT_W'(CAPACITY)) begin
                    n_status = omse_pkg::ST_FULL;
                end else begin
                    n_status = omse_pkg::ST_OK;
                    n_count  = r_count + 1'b1;
                end
            end
            omse_pkg::OP_REMOVE: begin
                if (present) begin
                    n_status = omse_pkg::ST_OK;
                    n_occ    = omse_pkg::OCC_W'(copies);
                    n_count  = r_count - copies;
                end
            end
            omse_pkg::OP_SEARCH: begin
                n_status = present ? omse_pkg::ST_OK : omse_pkg::ST_NONE;
            end
            omse_pkg::OP_COUNT: begin
                n_status = present ? omse_pkg::ST_OK : omse_pkg::ST_NONE;
                n_occ    = omse_pkg::OCC_W'(copies);
            end
            omse_pkg::OP_LOWER: begin
                if (r_lo < r_count) begin
                    n_status = omse_pkg::ST_OK;
                    n_ans    = r_succ;
                end
            end
            omse_pkg::OP_UPPER: begin
                if (r_hi < r_count) begin
                    n_status = omse_pkg::ST_OK;
                    n_ans    = r_succ;
                end
            end
            omse_pkg::OP_CLOSEST: begin
                if (present) begin
                    n_status = omse_pkg::ST_OK;
                    n_ans    = r_key;
                end else if (r_lo != '0 && r_lo < r_count) begin
                    n_status = omse_pkg::ST_OK;
                    n_ans    = (ds < dp) ? r_succ : r_pred;
                end else if (r_lo != '0) begin
                    n_status = omse_pkg::ST_OK;
                    n_ans    = r_pred;
                end else if (r_lo < r_count) begin
                    n_status = omse_pkg::ST_OK;
                    n_ans    = r_succ;
                end
            end
            default: begin
                n_pres = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_key  <= i_key;
            r_op   <= i_opcode;
            r_low  <= '0;
            r_high <= r_count;
        end
        if (i_cmd.step_lo || i_cmd.step_hi) begin
            if (i_cmd.step_lo ? rd_lt : rd_le) begin
                r_low <= mid + 1'b1;
            end else begin
                r_high <= mid;
            end
        end
        if (i_cmd.save_lo) begin
            r_lo   <= r_low;
            r_high <= r_count;
        end
        if (i_cmd.save_hi) begin
            r_hi <= r_low;
        end
        if (i_cmd.ptr_ins) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_rem) begin
            r_ptr <= r_hi;
        end else if (i_cmd.wr_ins) begin
            r_ptr <= r_ptr - 1'b1;
        end else if (i_cmd.wr_rem) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.save_succ) begin
            r_succ <= r_rdata;
        end
        if (i_cmd.save_pred) begin
            r_pred <= r_rdata;
        end
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_ans    <= n_ans;
            r_occ    <= n_occ;
            r_pres   <= n_pres;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_answer_value = r_ans;
    assign o_occurrences  = r_occ;
    assign o_present      = r_pres;

    assign o_stat.bs_done  = (r_low == r_high);
    assign o_stat.full     = (r_count >= CNT_W'(CAPACITY));
    assign o_stat.present  = present;
    assign o_stat.ins_more = (r_ptr > r_lo);
    assign o_stat.rem_more = (r_ptr < r_count);
    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_stat.op       = r_op;
endmodule

[rtl/core/ordered_multiset_engine.sv]
// Flow: a binary search for the lower bound, then one for the upper bound over N keys stored.
// Bound queries then read the successor key; closest also reads the predecessor key.
// Insert moves keys up one slot at a time, then writes the key; remove moves keys down.
// Throughput: one request at a time; o_ready is high only while the controller is idle.
// A finished result waits in the output register; the next request is taken after it is loaded.
// Reset: synchronous active low; empties the table, no clearing pass is needed.
module ordered_multiset_engine #(
    parameter int CAPACITY  = omse_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = omse_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [omse_pkg::OP_W-1:0]     i_opcode,
    input  logic signed [KEY_WIDTH-1:0]   i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [omse_pkg::STATUS_W-1:0] o_status,
    output logic signed [KEY_WIDTH-1:0]   o_answer_value,
    output logic [omse_pkg::OCC_W-1:0]    o_occurrences,
    output logic                          o_present
);
    omse_pkg::t_cmd  cmd;
    omse_pkg::t_stat stat;

    omse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    omse_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_opcode),
        .i_key          (i_key),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_answer_value (o_answer_value),
        .o_occurrences  (o_occurrences),
        .o_present      (o_present),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );
endmodule

[rtl/core/omse_checker.sv]
`include "ordered_multiset_engine_macros.svh"
module omse_checker #(
    parameter int KEY_WIDTH = omse_pkg::KEY_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [omse_pkg::STATUS_W-1:0] o_status,
    input logic [KEY_WIDTH-1:0]          o_answer_value
);
    `OME_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)
    `OME_ASSERT_NOW(a_status_code, o_valid, o_status <= omse_pkg::ST_FULL)
    `OME_ASSERT_NOW(a_no_answer_zero, o_valid && o_status != omse_pkg::ST_OK, o_answer_value == '0)
    `OME_ASSERT_NEXT(a_one_in_flight, i_valid && o_ready, !o_ready)
endmodule

bind ordered_multiset_engine omse_checker #(.KEY_WIDTH(KEY_WIDTH)) u_omse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_answer_value (o_answer_value)
);
